@@ rtl/alm_pkg.sv @@
// Package for the array linked list manager: command and status codes,
// the queue entry type shared by front and back end. No dependencies.
package alm_pkg;

  localparam int CMD_W = 3;
  localparam int ST_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_AFTER  = 3'd0,
    CMD_INS_BEFORE = 3'd1,
    CMD_PUSH       = 3'd2,
    CMD_ERASE      = 3'd3,
    CMD_POP        = 3'd4,
    CMD_FIND       = 3'd5,
    CMD_LINEARIZE  = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_UNUSED   = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_BEFORE   = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_t;

  // Item as it leaves the front end: command plus operands, with the slot
  // range check already made.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  slot;
    logic        slot_oob;
    logic [63:0] value;
    logic [7:0]  pos;
  } cmd_item_t;

endpackage

@@ rtl/alm_front.sv @@
// Front end of the list manager: accepts command items and classifies them
// into a two-entry queue for the back end. Depends on alm_pkg.
module alm_front #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_cmd,
  input  logic [7:0]          in_slot,
  input  logic [31:0]         in_value,
  input  logic [7:0]          in_pos,
  output logic                q_valid,
  input  logic                q_ready,
  output alm_pkg::cmd_item_t  q_item
);
  import alm_pkg::*;

  cmd_item_t  buf0, buf1;
  logic [1:0] fill;
  cmd_item_t  item_new;
  logic       push, pop;

  always_comb begin
    item_new.cmd      = cmd_t'(in_cmd);
    item_new.slot     = in_slot;
    item_new.slot_oob = (32'(in_slot) >= 32'(CAPACITY));
    item_new.value    = 64'(in_value) & ((VALUE_WIDTH >= 64) ? '1 :
                        ((64'd1 << VALUE_WIDTH) - 64'd1));
    item_new.pos      = in_pos;
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = buf0;
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
    end
    if (pop) begin
      buf0 <= (fill == 2'd2) ? buf1 : item_new;
    end else if (push && fill == 2'd0) begin
      buf0 <= item_new;
    end
    if (push && ((fill == 2'd1 && !pop) || (fill == 2'd2))) begin
      buf1 <= item_new;
    end
  end
endmodule

@@ rtl/alm_back.sv @@
// Back end of the list manager: a sequencer over the link, value and used
// stores that carries out one command at a time. Depends on alm_pkg.
module alm_back #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  alm_pkg::cmd_item_t q_item,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [2:0]         res_status,
  output logic [7:0]         res_slot,
  output logic [31:0]        res_value,
  output logic [7:0]         res_head,
  output logic [7:0]         res_tail,
  output logic [7:0]         res_count,
  output logic               res_ordered
);
  import alm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD1, S_RD2, S_CHECK, S_INS, S_ERA, S_FIND,
    S_LIN_WALK, S_LIN_WR, S_DONE
  } state_t;

  state_t state;

  // stores: next and prev links, values, scratch
  logic [AW-1:0]          nxt_mem [CAPACITY];
  logic [AW-1:0]          prv_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] scr_mem [CAPACITY];
  logic                   used_mem [CAPACITY];

  logic [AW-1:0] head, tail, free_first, free_last, cnt;
  logic          free_none, ordered;
  logic [AW:0]   clr_idx;
  cmd_item_t     it;
  logic [AW-1:0] s, a, p, n, k, w;
  logic [AW-1:0] pn, nx, fnext;
  logic          used_rd, phase;
  logic [AW:0]   cnt_w;
  logic [VALUE_WIDTH-1:0] v_rd, lv;
  logic [2:0]    st;
  logic [7:0]    sout;
  logic [31:0]   vout;
  logic          out_valid;

  assign q_ready = (state == S_IDLE) && !out_valid;
  assign res_valid   = out_valid;
  assign res_status  = st;
  assign res_slot    = sout;
  assign res_value   = vout;
  assign res_head    = 8'(head);
  assign res_tail    = 8'(tail);
  assign res_count   = 8'(cnt);
  assign res_ordered = ordered;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      head       <= '0;
      tail       <= '0;
      cnt        <= '0;
      free_first <= AW'(1);
      free_last  <= LAST;
      free_none  <= 1'b0;
      ordered    <= 1'b1;
      out_valid  <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (out_valid && res_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          // one slot a cycle: rebuild free chain and clear used marks
          nxt_mem[clr_idx[AW-1:0]] <= (clr_idx == '0 || clr_idx[AW-1:0] == LAST) ?
                                      '0 : clr_idx[AW-1:0] + AW'(1);
          prv_mem[clr_idx[AW-1:0]] <= '0;
          used_mem[clr_idx[AW-1:0]] <= (clr_idx == '0);
          clr_idx <= clr_idx + (AW+1)'(1);
          if (clr_idx[AW-1:0] == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            it    <= q_item;
            st    <= ST_OK;
            sout  <= '0;
            vout  <= '0;
            fnext <= nxt_mem[free_first];
            phase <= 1'b0;
            case (q_item.cmd)
              CMD_INS_AFTER, CMD_INS_BEFORE, CMD_ERASE: begin
                s <= q_item.slot[AW-1:0];
                state <= q_item.slot_oob ? S_DONE : S_RD1;
                if (q_item.slot_oob) st <= ST_UNUSED;
              end
              CMD_PUSH: begin
                a  <= tail;
                nx <= '0;
                state <= free_none ? S_DONE : S_INS;
                if (free_none) st <= ST_FULL;
              end
              CMD_POP: begin
                s <= tail;
                if (cnt == '0 || tail == '0) begin
                  st <= ST_EMPTY;
                  state <= S_DONE;
                end else state <= S_RD1;
              end
              CMD_FIND: begin
                w <= head;
                k <= AW'(1);
                st <= ST_NOTFOUND;
                state <= (q_item.pos == '0) ? S_DONE : S_FIND;
              end
              CMD_LINEARIZE: begin
                w <= head;
                cnt_w <= '0;
                state <= S_LIN_WALK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD1: begin
          // the sentinel's links live in head and tail
          p       <= (s == '0) ? tail : prv_mem[s];
          n       <= (s == '0) ? head : nxt_mem[s];
          v_rd    <= val_mem[s];
          used_rd <= used_mem[s];
          state   <= S_RD2;
        end
        S_RD2: begin
          pn <= (p == '0) ? head : nxt_mem[p];
          if (!used_rd || (it.cmd == CMD_ERASE && s == '0)) begin
            st <= ST_UNUSED;
            state <= S_DONE;
          end else state <= S_CHECK;
        end
        S_CHECK: begin
          // links agree check first
          if (pn != s) begin
            st <= ST_MISMATCH;
            state <= S_DONE;
          end else if (it.cmd == CMD_ERASE || it.cmd == CMD_POP) begin
            state <= S_ERA;
          end else if (it.cmd == CMD_INS_BEFORE && s == '0) begin
            st <= ST_BEFORE;
            state <= S_DONE;
          end else if (free_none) begin
            st <= ST_FULL;
            state <= S_DONE;
          end else begin
            a  <= (it.cmd == CMD_INS_BEFORE) ? p : s;
            nx <= (it.cmd == CMD_INS_BEFORE) ? s : n;
            state <= S_INS;
          end
        end
        S_INS: begin
          if (a != tail) ordered <= 1'b0;
          if (free_first == free_last) free_none <= 1'b1;
          else free_first <= fnext;
          val_mem[free_first]  <= it.value[VALUE_WIDTH-1:0];
          used_mem[free_first] <= 1'b1;
          nxt_mem[free_first]  <= nx;
          prv_mem[free_first]  <= a;
          if (a == '0) head <= free_first;
          else nxt_mem[a] <= free_first;
          if (nx == '0) tail <= free_first;
          else prv_mem[nx] <= free_first;
          cnt  <= cnt + AW'(1);
          sout <= 8'(free_first);
          state <= S_DONE;
        end
        S_ERA: begin
          if (s != head) ordered <= 1'b0;
          vout <= 32'(v_rd);
          if (p == '0) head <= n;
          else nxt_mem[p] <= n;
          if (n == '0) tail <= p;
          else prv_mem[n] <= p;
          if (free_none) begin
            free_first <= s;
            free_none  <= 1'b0;
          end else nxt_mem[free_last] <= s;
          free_last   <= s;
          nxt_mem[s]  <= '0;
          prv_mem[s]  <= '0;
          used_mem[s] <= 1'b0;
          cnt <= cnt - AW'(1);
          state <= S_DONE;
        end
        S_FIND: begin
          if (w == '0) state <= S_DONE;
          else if (8'(k) == it.pos) begin
            st <= ST_OK;
            sout <= 8'(w);
            state <= S_DONE;
          end else begin
            w <= nxt_mem[w];
            k <= k + AW'(1);
            if (k == LAST) state <= S_DONE;
          end
        end
        S_LIN_WALK: begin
          // read the value, then store it in scratch and follow the link
          if (!phase) begin
            if (w == '0 || cnt_w == (AW+1)'(CAPACITY - 1)) begin
              w <= AW'(1);
              state <= S_LIN_WR;
            end else begin
              lv <= val_mem[w];
              phase <= 1'b1;
            end
          end else begin
            scr_mem[cnt_w[AW-1:0] + AW'(1)] <= lv;
            cnt_w <= cnt_w + (AW+1)'(1);
            w <= nxt_mem[w];
            phase <= 1'b0;
          end
        end
        S_LIN_WR: begin
          if ((AW+1)'(w) <= cnt_w && !phase) begin
            lv <= scr_mem[w];
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if ((AW+1)'(w) <= cnt_w) begin
              val_mem[w]  <= lv;
              used_mem[w] <= 1'b1;
              nxt_mem[w]  <= ((AW+1)'(w) == cnt_w) ? '0 : w + AW'(1);
              prv_mem[w]  <= w - AW'(1);
            end else begin
              used_mem[w] <= 1'b0;
              prv_mem[w]  <= '0;
              nxt_mem[w]  <= (w == LAST) ? '0 : w + AW'(1);
            end
            w <= w + AW'(1);
            if (w == LAST) begin
              head <= (cnt_w == '0) ? '0 : AW'(1);
              tail <= cnt_w[AW-1:0];
              cnt  <= cnt_w[AW-1:0];
              free_none  <= (cnt_w >= (AW+1)'(CAPACITY - 1));
              free_first <= (cnt_w >= (AW+1)'(CAPACITY - 1)) ? '0 :
                            cnt_w[AW-1:0] + AW'(1);
              free_last  <= LAST;
              ordered    <= 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/array_linked_list_manager.sv @@
// Top level of the array linked list manager: front end queue plus
// sequencing back end. Depends on alm_pkg, alm_front, alm_back.
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: cmd[2:0] slot[10:3] item_value[42:11] logical_pos[50:43]
//  m_axis  | out | tdata: status[2:0] slot_out[10:3] value_out[42:11]
//          |     |        head[50:43] tail[58:51] count[66:59] is_ordered[67]
//
// Insert, erase and pop read the slot, its links and its neighbour's link before
// they write the stores (dependent store reads and writes); push writes them
// straight away. Find walks the links to the position; linearize walks the links
// into scratch, then rewrites every slot. The back end takes its next item only
// once its result has met a ready receiver.
// After reset a clearing pass over all CAPACITY slots rebuilds the free chain.
// The front queue holds up to two items while the back end is busy or stalled.
module array_linked_list_manager #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // cmd, slot, item_value, logical_pos
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // status, slot_out, value_out, head_slot,
                                     // tail_slot, item_count, is_ordered
);
  import alm_pkg::*;

  logic       q_valid, q_ready;
  cmd_item_t  q_item;
  logic [2:0] r_status;
  logic [7:0] r_slot, r_head, r_tail, r_count;
  logic [31:0] r_value;
  logic       r_ordered;

  alm_front #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(s_axis_tdata[2:0]), .in_slot(s_axis_tdata[10:3]),
    .in_value(s_axis_tdata[42:11]), .in_pos(s_axis_tdata[50:43]),
    .q_valid, .q_ready, .q_item
  );

  alm_back #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_status(r_status), .res_slot(r_slot), .res_value(r_value),
    .res_head(r_head), .res_tail(r_tail), .res_count(r_count),
    .res_ordered(r_ordered)
  );

  assign m_axis_tdata = {4'd0, r_ordered, r_count, r_tail, r_head, r_value,
                         r_slot, r_status};

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (r_status != 3'd7))
    else $error("status code out of range");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && r_count == 8'd0) |-> (r_head == 8'd0 && r_tail == 8'd0))
    else $error("empty list with nonzero head or tail");
endmodule

@@ tb/array_linked_list_manager_test.sv @@
// Testbench for array_linked_list_manager: list commands go in and status
// items are checked against an in-bench predictor. Depends on alm_pkg.
`timescale 1ns / 1ps

module array_linked_list_manager_test;
  import alm_pkg::*;

  localparam int NSLOT      = 256;
  localparam int N_RANDOM   = 1950;
  localparam int TAIL_WAIT  = 700;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct packed {
    status_t     st;
    logic [7:0]  slot;
    logic [31:0] val;
    logic [7:0]  head;
    logic [7:0]  tail;
    logic [7:0]  count;
    logic        ordered;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  array_linked_list_manager dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [7:0]  lnk_next [NSLOT];
  logic [7:0]  lnk_prev [NSLOT];
  logic [31:0] val_store [NSLOT];
  logic        in_use [NSLOT];
  logic [7:0]  spare_first, spare_last;
  logic        free_empty;
  int          n_items;
  logic        ordered;

  logic [55:0]  pending_items[$];
  list_result_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_total = 0;
  int n_full = 0;
  int n_lin = 0;
  int n_checked = 0;
  int cycles = 0;

  task automatic take_free(output logic [7:0] s);
    s = spare_first;
    if (s == spare_last) free_empty = 1'b1;
    else spare_first = lnk_next[s];
  endtask

  task automatic give_free(input logic [7:0] s);
    if (free_empty) begin
      spare_first = s;
      free_empty = 1'b0;
    end else begin
      lnk_next[spare_last] = s;
    end
    spare_last = s;
    lnk_next[s] = 8'd0;
    lnk_prev[s] = 8'd0;
    in_use[s] = 1'b0;
  endtask

  task automatic link_in(input logic [7:0] anchor, input logic [31:0] v,
                         output status_t st, output logic [7:0] taken);
    logic [7:0] s, nx;
    taken = 8'd0;
    if (free_empty) begin
      st = ST_FULL;
      n_full++;
    end else begin
      if (anchor != lnk_prev[0]) ordered = 1'b0;
      take_free(s);
      nx = lnk_next[anchor];
      val_store[s] = v;
      in_use[s] = 1'b1;
      lnk_next[s] = nx;
      lnk_prev[s] = anchor;
      lnk_next[anchor] = s;
      lnk_prev[nx] = s;
      n_items++;
      taken = s;
      st = ST_OK;
    end
  endtask

  task automatic unlink(input logic [7:0] s, output status_t st, output logic [31:0] v);
    logic [7:0] p, n;
    v = '0;
    if (s == 0 || !in_use[s]) st = ST_UNUSED;
    else if (lnk_next[lnk_prev[s]] != s) st = ST_MISMATCH;
    else begin
      if (s != lnk_next[0]) ordered = 1'b0;
      v = val_store[s];
      p = lnk_prev[s];
      n = lnk_next[s];
      lnk_next[p] = n;
      lnk_prev[n] = p;
      give_free(s);
      n_items--;
      st = ST_OK;
    end
  endtask

  task automatic compact_list();
    logic [31:0] gathered [NSLOT];
    int n, i;
    logic [7:0] j;
    n = 0;
    j = lnk_next[0];
    while (j != 0 && n < NSLOT - 1) begin
      gathered[n + 1] = val_store[j];
      n++;
      j = lnk_next[j];
    end
    for (i = 1; i < NSLOT; i++) begin
      if (i <= n) begin
        val_store[i] = gathered[i];
        in_use[i] = 1'b1;
        lnk_next[i] = (i == n) ? 8'd0 : 8'(i + 1);
        lnk_prev[i] = 8'(i - 1);
      end else begin
        in_use[i] = 1'b0;
        lnk_prev[i] = 8'd0;
        lnk_next[i] = (i == NSLOT - 1) ? 8'd0 : 8'(i + 1);
      end
    end
    lnk_next[0] = (n == 0) ? 8'd0 : 8'd1;
    lnk_prev[0] = 8'(n);
    n_items = n;
    free_empty = (n >= NSLOT - 1);
    spare_first = free_empty ? 8'd0 : 8'(n + 1);
    spare_last = 8'(NSLOT - 1);
    ordered = 1'b1;
  endtask

  // Applies one command to the predictor and queues the status item it yields.
  task automatic apply_command(input cmd_t c, input logic [7:0] s,
                               input logic [31:0] v, input logic [7:0] pos);
    list_result_t r;
    status_t st;
    logic [7:0] so, j;
    logic [31:0] vo;
    int k;
    st = ST_OK;
    so = 8'd0;
    vo = '0;
    case (c)
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (!in_use[s]) st = ST_UNUSED;
        else if (lnk_next[lnk_prev[s]] != s) st = ST_MISMATCH;
        else if (c == CMD_INS_BEFORE && s == 0) st = ST_BEFORE;
        else link_in(c == CMD_INS_BEFORE ? lnk_prev[s] : s, v, st, so);
      end
      CMD_PUSH: link_in(lnk_prev[0], v, st, so);
      CMD_ERASE: unlink(s, st, vo);
      CMD_POP: begin
        if (n_items == 0 || lnk_prev[0] == 0) st = ST_EMPTY;
        else unlink(lnk_prev[0], st, vo);
      end
      CMD_FIND: begin
        st = ST_NOTFOUND;
        j = lnk_next[0];
        k = 1;
        if (pos != 0) begin
          while (j != 0 && k <= NSLOT) begin
            if (k == pos) begin
              st = ST_OK;
              so = j;
              break;
            end
            j = lnk_next[j];
            k++;
          end
        end
      end
      CMD_LINEARIZE: begin
        compact_list();
        n_lin++;
      end
      default: ;
    endcase
    r.st = st;
    r.slot = so;
    r.val = vo;
    r.head = lnk_next[0];
    r.tail = lnk_prev[0];
    r.count = 8'(n_items);
    r.ordered = ordered;
    expected_results.push_back(r);
    pending_items.push_back({5'd0, pos, v, s, c});
    n_total++;
  endtask

  // Mostly a slot that holds an item (or the sentinel), sometimes any slot.
  function automatic logic [7:0] pick_slot();
    logic [7:0] j;
    int k;
    if (n_items > 0 && $urandom_range(0, 3) != 0) begin
      j = 8'd0;
      for (k = $urandom_range(0, n_items); k > 0; k--) j = lnk_next[j];
      return j;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_command(input int grow_pct, input int shrink_pct);
    int roll;
    logic [7:0] pos;
    roll = $urandom_range(0, 99);
    pos = (n_items > 0 && $urandom_range(0, 3) != 0) ? 8'($urandom_range(1, n_items))
                                                   : 8'($urandom_range(0, 255));
    if (roll < grow_pct) begin
      case ($urandom_range(0, 2))
        0: apply_command(CMD_INS_AFTER, pick_slot(), $urandom, pos);
        1: apply_command(CMD_INS_BEFORE, pick_slot(), $urandom, pos);
        default: apply_command(CMD_PUSH, pick_slot(), $urandom, pos);
      endcase
    end else if (roll < grow_pct + shrink_pct) begin
      if ($urandom_range(0, 2) == 0) apply_command(CMD_POP, pick_slot(), $urandom, pos);
      else apply_command(CMD_ERASE, pick_slot(), $urandom, pos);
    end else if (roll < 98) begin
      apply_command(CMD_FIND, pick_slot(), $urandom, pos);
    end else if (roll == 98) begin
      apply_command(CMD_LINEARIZE, pick_slot(), $urandom, pos);
    end else begin
      apply_command(CMD_NOP, pick_slot(), $urandom, pos);
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at item %0d: %s got %0h expected %0h", n_checked, field, got, want);
    errors++;
  endtask

  // driver
  int  in_gap = 0;
  logic quiet;
  assign quiet = (n_sent > (n_total * 85) / 100);

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
        s_axis_tdata <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        n_sent <= n_sent + 1;
      end else begin
        if (pending_items.size() > 0) in_gap <= $urandom_range(1, 11) - 1;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int out_gap = 0;
  always @(posedge clk) begin
    list_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.st      = status_t'(m_axis_tdata[2:0]);
        got.slot    = m_axis_tdata[10:3];
        got.val     = m_axis_tdata[42:11];
        got.head    = m_axis_tdata[50:43];
        got.tail    = m_axis_tdata[58:51];
        got.count   = m_axis_tdata[66:59];
        got.ordered = m_axis_tdata[67];
        if (expected_results.size() == 0) begin
          report("unexpected item", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.st != want.st) report("status", got.st, want.st);
          if (got.slot != want.slot) report("slot_out", got.slot, want.slot);
          if (got.val != want.val) report("value_out", got.val, want.val);
          if (got.head != want.head) report("head_slot", got.head, want.head);
          if (got.tail != want.tail) report("tail_slot", got.tail, want.tail);
          if (got.count != want.count) report("item_count", got.count, want.count);
          if (got.ordered != want.ordered) report("is_ordered", got.ordered, want.ordered);
        end
        n_checked <= n_checked + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int i, p;
    for (i = 0; i < NSLOT; i++) begin
      lnk_next[i] = (i == 0 || i == NSLOT - 1) ? 8'd0 : 8'(i + 1);
      lnk_prev[i] = 8'd0;
      in_use[i] = (i == 0);
    end
    spare_first = 8'd1;
    spare_last = 8'(NSLOT - 1);
    free_empty = 1'b0;
    n_items = 0;
    ordered = 1'b1;

    // directed: empty list cases, extremes, each command
    apply_command(CMD_POP, 8'd0, 32'd0, 8'd0);
    apply_command(CMD_FIND, 8'd0, 32'd0, 8'd0);
    apply_command(CMD_FIND, 8'd0, 32'd0, 8'd1);
    apply_command(CMD_ERASE, 8'd0, 32'd0, 8'd0);
    apply_command(CMD_ERASE, 8'd255, 32'd0, 8'd0);
    apply_command(CMD_INS_AFTER, 8'd5, 32'd1, 8'd0);
    apply_command(CMD_INS_BEFORE, 8'd0, 32'd2, 8'd0);
    apply_command(CMD_PUSH, 8'd0, 32'h7fffffff, 8'd0);
    apply_command(CMD_PUSH, 8'd0, 32'h80000000, 8'd0);
    apply_command(CMD_INS_AFTER, 8'd0, 32'd0, 8'd0);       // new head, order lost
    apply_command(CMD_INS_BEFORE, 8'd1, 32'hffffffff, 8'd0);
    apply_command(CMD_INS_AFTER, 8'd2, 32'h12345678, 8'd0); // after tail
    apply_command(CMD_FIND, 8'd0, 32'd0, 8'd1);
    apply_command(CMD_FIND, 8'd0, 32'd0, 8'd5);
    apply_command(CMD_FIND, 8'd0, 32'd0, 8'd6);
    apply_command(CMD_FIND, 8'hff, 32'hffffffff, 8'd255);
    apply_command(CMD_ERASE, 8'd1, 32'd0, 8'd0);            // middle
    apply_command(CMD_NOP, 8'hff, 32'hffffffff, 8'hff);
    apply_command(CMD_LINEARIZE, 8'd0, 32'd0, 8'd0);
    apply_command(CMD_POP, 8'd0, 32'd0, 8'd0);
    apply_command(CMD_ERASE, 8'd1, 32'd0, 8'd0);            // head
    apply_command(CMD_INS_AFTER, 8'd1, 32'd7, 8'd0);        // freed slot

    // random: fill towards full, drain, refill, then a balanced mix
    for (p = 0; p < N_RANDOM; p++) begin
      if (p < 650) random_command(80, 8);
      else if (p < 1150) random_command(12, 78);
      else if (p < 1450) random_command(70, 15);
      else random_command(42, 42);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d commands sent, %0d status items checked", n_total, n_checked);
    $display("%0d inserts refused as full, %0d compactions", n_full, n_lin);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
